/* src/iscc_pkg.sv */
// Shared constants and types for the insertion sort block.
package iscc_pkg;

    localparam int MaxItems   = 64;
    localparam int DataW      = 32;
    localparam int SumW       = 11;
    localparam int CountW     = $clog2(MaxItems + 1);
    localparam int GroupSize  = 8;
    localparam int NumGroups  = (MaxItems + GroupSize - 1) / GroupSize;
    localparam int GrpCntW    = $clog2(GroupSize + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CMP,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sum;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic one_left;
    } t_status;

endpackage

/* src/iscc_ifs.sv */
// Stream interfaces for the input values and the sorted results.
interface iscc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [iscc_pkg::DataW-1:0] value;
    logic                              last;

    modport source(output valid, output value, output last, input ready);
    modport sink(input valid, input value, input last, output ready);
endinterface

interface iscc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [iscc_pkg::DataW-1:0] sorted_value;
    logic                              run_end;
    logic [iscc_pkg::SumW-1:0]         comparison_total;
    logic                              overflow;

    modport source(output valid, output sorted_value, output run_end,
                   output comparison_total, output overflow, input ready);
    modport sink(input valid, input sorted_value, input run_end,
                 input comparison_total, input overflow, output ready);
endinterface

/* src/iscc_dp.sv */
// Datapath: compare-and-shift cell row, registered compare count tree, run output.
module iscc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iscc_pkg::t_cmd                    i_cmd,
    input  logic signed [iscc_pkg::DataW-1:0] i_value,
    input  logic                              i_last,
    output iscc_pkg::t_status                 o_status,
    output logic signed [iscc_pkg::DataW-1:0] o_sorted_value,
    output logic                              o_run_end,
    output logic [iscc_pkg::SumW-1:0]         o_comparison_total,
    output logic                              o_overflow
);

    logic signed [iscc_pkg::DataW-1:0] r_store [iscc_pkg::MaxItems];
    logic signed [iscc_pkg::DataW-1:0] n_store [iscc_pkg::MaxItems];
    logic signed [iscc_pkg::DataW-1:0] r_new;
    logic                              r_last;
    logic                              r_ins;
    logic [iscc_pkg::GrpCntW-1:0]      r_grp [iscc_pkg::NumGroups];
    logic [iscc_pkg::GrpCntW-1:0]      n_grp [iscc_pkg::NumGroups];
    logic [iscc_pkg::CountW-1:0]       r_count;
    logic [iscc_pkg::SumW-1:0]         r_sum;
    logic [iscc_pkg::SumW-1:0]         n_sum;
    logic                              r_drop;

    logic [iscc_pkg::MaxItems-1:0]                       mv;
    logic [iscc_pkg::NumGroups*iscc_pkg::GroupSize-1:0]  mv_pad;
    logic [iscc_pkg::CountW-1:0]                         greater;
    logic                                                full;
    logic                                                one_left;

    assign full     = (r_count == iscc_pkg::CountW'(iscc_pkg::MaxItems));
    assign one_left = (r_count == iscc_pkg::CountW'(1));

    // Occupied cells holding a value strictly above the new one move up.
    always_comb begin
        for (int i = 0; i < iscc_pkg::MaxItems; i++) begin
            mv[i] = (iscc_pkg::CountW'(i) < r_count) && (r_store[i] > r_new);
        end
        mv_pad = (iscc_pkg::NumGroups*iscc_pkg::GroupSize)'(mv);
    end

    always_comb begin
        for (int g = 0; g < iscc_pkg::NumGroups; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < iscc_pkg::GroupSize; b++) begin
                n_grp[g] = n_grp[g]
                         + iscc_pkg::GrpCntW'(mv_pad[g*iscc_pkg::GroupSize + b]);
            end
        end
    end

    always_comb begin
        greater = '0;
        for (int g = 0; g < iscc_pkg::NumGroups; g++) begin
            greater = greater + iscc_pkg::CountW'(r_grp[g]);
        end
        // One extra compare stops the scan unless the value lands at the bottom.
        n_sum = r_sum + iscc_pkg::SumW'(greater)
              + iscc_pkg::SumW'(greater < r_count);
    end

    always_comb begin
        for (int i = 0; i < iscc_pkg::MaxItems; i++) begin
            n_store[i] = r_store[i];
        end
        if (i_cmd.cmp && !full) begin
            if (mv[0] || (r_count == '0)) begin
                n_store[0] = r_new;
            end
            for (int i = 1; i < iscc_pkg::MaxItems; i++) begin
                if (mv[i] || (iscc_pkg::CountW'(i) == r_count)) begin
                    n_store[i] = mv[i-1] ? r_store[i-1] : r_new;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < iscc_pkg::MaxItems - 1; i++) begin
                n_store[i] = r_store[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        if (i_cmd.load) begin
            r_new <= i_value;
        end
        if (i_cmd.cmp) begin
            r_grp <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_ins   <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_last;
            end
            if (i_cmd.cmp) begin
                r_ins <= !full;
            end
            if (i_cmd.sum) begin
                if (r_ins) begin
                    r_count <= r_count + iscc_pkg::CountW'(1);
                    r_sum   <= n_sum;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.shift) begin
                r_count <= r_count - iscc_pkg::CountW'(1);
                // Clear totals once the final element of the run leaves.
                if (one_left) begin
                    r_sum  <= '0;
                    r_drop <= 1'b0;
                end
            end
        end
    end

    assign o_status.full     = full;
    assign o_status.last     = r_last;
    assign o_status.one_left = one_left;

    assign o_sorted_value     = r_store[0];
    assign o_run_end          = one_left;
    assign o_comparison_total = r_sum;
    assign o_overflow         = r_drop;

endmodule

/* src/iscc_ctrl.sv */
// Controller: sequences load, insert, count and run output for each item.
module iscc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  iscc_pkg::t_status i_status,
    output iscc_pkg::t_cmd    o_cmd
);

    iscc_pkg::t_state r_state;
    iscc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iscc_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            iscc_pkg::ST_LOAD: begin
                if (i_in_valid) begin
                    n_state = iscc_pkg::ST_CMP;
                end
            end
            iscc_pkg::ST_CMP: begin
                n_state = iscc_pkg::ST_SUM;
            end
            iscc_pkg::ST_SUM: begin
                n_state = i_status.last ? iscc_pkg::ST_EMIT : iscc_pkg::ST_LOAD;
            end
            iscc_pkg::ST_EMIT: begin
                if (i_out_ready && i_status.one_left) begin
                    n_state = iscc_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = iscc_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            iscc_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            iscc_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
            end
            iscc_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            iscc_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.shift = i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/insertion_sort_with_compare_count_top.sv */
// Top level of the insertion sort block with comparison count.
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    value[31:0] signed, last
//  o_out     out  valid / ready    sorted_value[31:0] signed, run_end,
//                                  comparison_total[10:0], overflow
//
// Each input transaction is accepted, compared and inserted in the cell row,
// then the registered per-group counts are added into the running total.
// After an item flagged last, the run leaves at one transaction per cycle while
// o_out is ready, lowest value first; each shifts the cell row down one place.
// Input is not accepted while an item is in work or the run is being output.
// Reset is synchronous, active low; the store needs no clearing pass.
module insertion_sort_with_compare_count_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iscc_in_if.sink      i_in,
    iscc_out_if.source   o_out
);

    iscc_pkg::t_cmd    cmd;
    iscc_pkg::t_status status;

    iscc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    iscc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_value            (i_in.value),
        .i_last             (i_in.last),
        .o_status           (status),
        .o_sorted_value     (o_out.sorted_value),
        .o_run_end          (o_out.run_end),
        .o_comparison_total (o_out.comparison_total),
        .o_overflow         (o_out.overflow)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input ready while run output pending");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item accepted during work");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.run_end) |=> !o_out.valid)
        else $error("output continues past run end");

    a_shift_only_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift |-> (o_out.valid && o_out.ready && !cmd.cmp))
        else $error("store shift without output transaction");

endmodule

/* test/insertion_sort_with_compare_count_top_test.sv */
// Testbench for the insertion sort block: directed and random sets checked against a predictor.
`timescale 1ns / 100ps

module insertion_sort_with_compare_count_top_test;

    localparam int HalfPeriod     = 6;
    localparam int ResetCycles    = 6;
    localparam int SettleCycles   = 6;
    localparam int LongHoldCycles = 300;
    localparam int StallLimit     = 3000;
    localparam int RandomValues   = 50;

    localparam logic signed [iscc_pkg::DataW-1:0] MinVal =
        {1'b1, {(iscc_pkg::DataW-1){1'b0}}};
    localparam logic signed [iscc_pkg::DataW-1:0] MaxVal =
        {1'b0, {(iscc_pkg::DataW-1){1'b1}}};

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_ready_mode;
    typedef enum {PICK_WIDE, PICK_TIES, PICK_EDGES} t_value_pick;

    typedef struct {
        logic signed [iscc_pkg::DataW-1:0] sorted_value;
        logic                              run_end;
        logic [iscc_pkg::SumW-1:0]         comparison_total;
        logic                              overflow;
    } t_sorted_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iscc_in_if  in_if();
    iscc_out_if out_if();

    insertion_sort_with_compare_count_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // Predictor state: the sorted store as the block should hold it
    logic signed [iscc_pkg::DataW-1:0] model_store [iscc_pkg::MaxItems];
    int                                model_count;
    logic [iscc_pkg::SumW-1:0]         model_sum;
    logic                              model_dropped;

    t_sorted_result expected_sorted[$];

    int  mismatch_count;
    int  sets_sent;
    int  values_sent;
    int  results_checked;
    int  overflow_sets;
    int  stall_cycles;
    bit  long_hold_req;
    bit  sender_gaps;
    int  burst_left;

    // Insert one accepted value and queue the sorted run when it closes a set
    task automatic predict_sorted_run(input logic signed [iscc_pkg::DataW-1:0] v,
                                      input logic is_last);
        int             greater;
        int             pos;
        t_sorted_result res;
        if (model_count < iscc_pkg::MaxItems) begin
            greater = 0;
            for (int i = 0; i < model_count; i++) begin
                if (model_store[i] > v) begin
                    greater++;
                end
            end
            // the scan stops on a compare unless it ran past every stored value
            model_sum = model_sum + iscc_pkg::SumW'(greater)
                      + iscc_pkg::SumW'(greater < model_count);
            pos = model_count - greater;
            for (int i = model_count; i > pos; i--) begin
                model_store[i] = model_store[i-1];
            end
            model_store[pos] = v;
            model_count++;
        end else begin
            model_dropped = 1'b1;
        end
        if (is_last) begin
            for (int i = 0; i < model_count; i++) begin
                res.sorted_value     = model_store[i];
                res.run_end          = (i == model_count - 1);
                res.comparison_total = model_sum;
                res.overflow         = model_dropped;
                expected_sorted.push_back(res);
            end
            sets_sent++;
            if (model_dropped) begin
                overflow_sets++;
            end
            model_count   = 0;
            model_sum     = '0;
            model_dropped = 1'b0;
        end
    endtask

    // Call at a rising edge; returns at the edge that accepted the transaction, or after an idle gap that follows it
    task automatic send_value(input logic signed [iscc_pkg::DataW-1:0] v, input logic is_last);
        int gap;
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= is_last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        predict_sorted_run(v, is_last);
        values_sent++;
        if (sender_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(6, 0);
                if (gap > 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(10, 1);
            end
        end
    endtask

    // Hold the input idle until every queued result has been checked
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (expected_sorted.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic signed [iscc_pkg::DataW-1:0] pick_value(t_value_pick pick);
        case (pick)
            PICK_TIES: return iscc_pkg::DataW'($urandom_range(6, 0)) - 3;
            PICK_EDGES: begin
                case ($urandom_range(5, 0))
                    0: return MinVal;
                    1: return MinVal + 1;
                    2: return MaxVal - 1;
                    3: return MaxVal;
                    4: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_value_pick random_pick();
        int r;
        r = $urandom_range(9, 0);
        if (r < 6) begin
            return PICK_WIDE;
        end else if (r < 9) begin
            return PICK_TIES;
        end
        return PICK_EDGES;
    endfunction

    task automatic test_single_element_sets();
        send_value(MinVal, 1'b1);
        send_value(MaxVal, 1'b1);
        send_value('0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_extremes_and_ties();
        send_value('0, 1'b0);
        send_value(MaxVal, 1'b0);
        send_value(MinVal, 1'b0);
        send_value('1, 1'b0);
        send_value(1, 1'b0);
        send_value(MaxVal, 1'b0);
        send_value(MinVal, 1'b0);
        send_value('0, 1'b0);
        send_value('1, 1'b0);
        send_value(32'sh5555_5555, 1'b0);
        send_value(32'shAAAA_AAAA, 1'b0);
        send_value(32'sh5555_5555, 1'b1);
        wait_for_results();
    endtask

    task automatic test_presorted_orders();
        for (int i = 1; i <= 5; i++) begin
            send_value(i, i == 5);
        end
        for (int i = 5; i >= 1; i--) begin
            send_value(i, i == 1);
        end
        wait_for_results();
    endtask

    // Strictly descending full set drives the comparison total to its peak;
    // the minimum then arrives on a full store, is dropped and must not lead the run
    task automatic test_full_store_and_drop();
        for (int i = 0; i < iscc_pkg::MaxItems; i++) begin
            send_value(MaxVal - i * 33554432, 1'b0);
        end
        send_value(MinVal, 1'b1);
        wait_for_results();
    endtask

    // Output held off while the next set is offered: input must stall behind the run
    task automatic test_output_backpressure();
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_value(pick_value(random_pick()), i == 15);
        end
        for (int i = 0; i < 8; i++) begin
            send_value(pick_value(random_pick()), i == 7);
        end
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_sets();
        int sent;
        int set_size;
        sent = 0;
        while (sent < RandomValues) begin
            if ($urandom_range(7, 0) == 0) begin
                set_size = $urandom_range(40, 13);
            end else begin
                set_size = $urandom_range(12, 1);
            end
            sender_gaps = ($urandom_range(3, 0) != 0);
            for (int i = 0; i < set_size; i++) begin
                send_value(pick_value(random_pick()), i == set_size - 1);
            end
            sent += set_size;
            if ($urandom_range(3, 0) == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    // Receiver: ready follows a changing pattern, with one long hold on request
    initial begin : drive_output_ready
        t_ready_mode mode;
        int          span;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            mode = t_ready_mode'($urandom_range(2, 0));
            span = $urandom_range(60, 10);
            for (int step = 0; step < span; step++) begin
                if (long_hold_req) begin
                    out_if.ready  <= 1'b0;
                    long_hold_req = 1'b0;
                    repeat (LongHoldCycles) @(posedge i_clk);
                end else begin
                    case (mode)
                        RX_ALWAYS:   out_if.ready <= 1'b1;
                        RX_RANDOM:   out_if.ready <= ($urandom_range(3, 0) != 0);
                        default:     out_if.ready <= (step % 3 == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_sorted_output
        t_sorted_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_checked++;
            if (expected_sorted.size() == 0) begin
                $error("unexpected transaction: sorted_value %0d, run_end %0b",
                       out_if.sorted_value, out_if.run_end);
                mismatch_count++;
            end else begin
                want = expected_sorted.pop_front();
                if (out_if.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           want.sorted_value, out_if.sorted_value);
                    mismatch_count++;
                end
                if (out_if.run_end !== want.run_end) begin
                    $error("run_end: expected %0b, actual %0b", want.run_end, out_if.run_end);
                    mismatch_count++;
                end
                if (out_if.comparison_total !== want.comparison_total) begin
                    $error("comparison_total: expected %0d, actual %0d",
                           want.comparison_total, out_if.comparison_total);
                    mismatch_count++;
                end
                if (out_if.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b", want.overflow, out_if.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("Timeout: no transaction for %0d cycles", StallLimit);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.value   <= '0;
        in_if.last    <= 1'b0;
        mismatch_count = 0;
        sets_sent      = 0;
        values_sent    = 0;
        results_checked = 0;
        overflow_sets  = 0;
        long_hold_req  = 1'b0;
        sender_gaps    = 1'b1;
        burst_left     = $urandom_range(10, 1);
        model_count    = 0;
        model_sum      = '0;
        model_dropped  = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_element_sets();
        test_extremes_and_ties();
        test_presorted_orders();
        test_full_store_and_drop();
        test_output_backpressure();
        test_random_sets();

        $display("Sorted %0d sets from %0d values, %0d of them with dropped values;",
                 sets_sent, values_sent, overflow_sets);
        $display("checked %0d sorted transactions, including a long output hold-off.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
